// ===== hw/rtl/ppwf_pkg.sv =====
// Shared constants, types and the arctangent table for the waypoint follower.
// No dependencies.
`timescale 1ns / 1ps
package ppwf_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    // CORDIC datapath widths
    localparam int CX_W = 28;
    localparam int CZ_W = 22;

    // angles in units of 2^-16 rad
    localparam logic signed [CZ_W-1:0] ANG_PI      = CZ_W'(205887);
    localparam logic signed [CZ_W-1:0] ANG_TWO_PI  = CZ_W'(411775);
    localparam logic signed [CZ_W-1:0] ANG_HALF_PI = CZ_W'(102944);
    localparam logic signed [CX_W-1:0] CORDIC_K    = CX_W'(10188012);

    localparam logic signed [17:0] PI_Q12 = 18'sd12868;
    localparam logic signed [14:0] W_MAX  = 15'sd12288;
    localparam logic signed [14:0] W_ONE  = 15'sd4096;

    // configuration register indexes
    localparam logic REG_GOAL_RADIUS = 1'b0;
    localparam logic REG_NUM_POINTS  = 1'b1;

    localparam logic [15:0] GOAL_RADIUS_RST = 16'd256;
    localparam logic [4:0]  NUM_POINTS_RST  = 5'd1;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    function automatic logic signed [CZ_W-1:0] atan_tab(input logic [3:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            4'd0:    v = CZ_W'(51472);
            4'd1:    v = CZ_W'(30386);
            4'd2:    v = CZ_W'(16055);
            4'd3:    v = CZ_W'(8150);
            4'd4:    v = CZ_W'(4091);
            4'd5:    v = CZ_W'(2047);
            4'd6:    v = CZ_W'(1024);
            4'd7:    v = CZ_W'(512);
            4'd8:    v = CZ_W'(256);
            4'd9:    v = CZ_W'(128);
            4'd10:   v = CZ_W'(64);
            4'd11:   v = CZ_W'(32);
            4'd12:   v = CZ_W'(16);
            4'd13:   v = CZ_W'(8);
            4'd14:   v = CZ_W'(4);
            default: v = CZ_W'(2);
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ppwf_item_if.sv =====
// Valid/ready channel interfaces for input items and results.
// No dependencies.
`timescale 1ns / 1ps
interface ppwf_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [14:0] yaw;

    modport source (output valid, cmd, slot, pos_x, pos_y, yaw, input ready);
    modport sink   (input valid, cmd, slot, pos_x, pos_y, yaw, output ready);
endinterface

interface ppwf_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         target_index;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               goal_reached;
    logic [16:0]        goal_distance;
    logic signed [14:0] angular_velocity;

    modport source (output valid, target_index, target_x, target_y, goal_reached,
                    goal_distance, angular_velocity, input ready);
    modport sink   (input valid, target_index, target_x, target_y, goal_reached,
                    goal_distance, angular_velocity, output ready);
endinterface

// ===== hw/rtl/ppwf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ppwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/ppwf_dist.sv =====
// Distance unit: dx^2 + dy^2 on one multiplier, then a bit-pair integer square root.
// No dependencies; ppwf_pkg is not used - standalone.
`timescale 1ns / 1ps
module ppwf_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    output logic               done,
    output logic [16:0]        root
);
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SQX  = 3'd1;
    localparam logic [2:0] PH_SQY  = 3'd2;
    localparam logic [2:0] PH_SUM  = 3'd3;
    localparam logic [2:0] PH_ROOT = 3'd4;

    logic [2:0]         ph_reg, ph_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [33:0]        prod_reg, prod_next;
    logic [33:0]        acc_reg, acc_next;
    logic [19:0]        rem_reg, rem_next;
    logic [16:0]        root_reg, root_next;
    logic               done_reg, done_next;
    logic signed [16:0] mul_op;
    logic signed [33:0] mul_res;
    logic [19:0]        rem_t;
    logic [19:0]        trial;

    assign mul_op  = (ph_reg == PH_SQX) ? dx_reg : dy_reg;
    assign mul_res = mul_op * mul_op;
    assign rem_t   = {rem_reg[17:0], acc_reg[33:32]};
    assign trial   = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        done_next = 1'b0;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    dx_next = dx;
                    dy_next = dy;
                    ph_next = PH_SQX;
                end
            end
            PH_SQX:
            begin
                prod_next = 34'(unsigned'(mul_res));
                ph_next   = PH_SQY;
            end
            PH_SQY:
            begin
                acc_next  = prod_reg;
                prod_next = 34'(unsigned'(mul_res));
                ph_next   = PH_SUM;
            end
            PH_SUM:
            begin
                acc_next  = acc_reg + prod_reg;
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
                ph_next   = PH_ROOT;
            end
            PH_ROOT:
            begin
                acc_next = {acc_reg[31:0], 2'b00};
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/ppwf_cordic.sv =====
// Shared 16-step CORDIC, vectoring (atan2) or rotation (sine) mode.
// Depends on ppwf_pkg.
`timescale 1ns / 1ps
module ppwf_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppwf_pkg::cordic_cmd_t             cmd,
    input  logic signed [ppwf_pkg::CX_W-1:0]  x0,
    input  logic signed [ppwf_pkg::CX_W-1:0]  y0,
    input  logic signed [ppwf_pkg::CZ_W-1:0]  z0,
    output logic                              done,
    output logic signed [ppwf_pkg::CX_W-1:0]  y,
    output logic signed [ppwf_pkg::CZ_W-1:0]  z
);
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic                             vec_reg, vec_next;
    logic [3:0]                       it_reg, it_next;
    logic signed [ppwf_pkg::CX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ppwf_pkg::CZ_W-1:0] z_reg, z_next;
    logic signed [ppwf_pkg::CX_W-1:0] xs, ys;
    logic                             s;

    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    // s: vectoring with y > 0, or rotation with angle < 0
    assign s  = vec_reg ? (y_reg > 0) : z_reg[ppwf_pkg::CZ_W-1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        vec_next  = vec_reg;
        it_next   = it_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1;
                vec_next  = cmd.vectoring;
                it_next   = '0;
                x_next    = x0;
                y_next    = y0;
                z_next    = z0;
            end
        end
        else
        begin
            if (s)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ppwf_pkg::atan_tab(it_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ppwf_pkg::atan_tab(it_reg);
            end
            it_next = it_reg + 4'd1;
            if (it_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
        it_reg  <= it_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign done = done_reg;
    assign y    = y_reg;
    assign z    = z_reg;
endmodule

// ===== hw/rtl/pure_pursuit_waypoint_follower_top.sv =====
// Pure pursuit waypoint follower: waypoint table, distance unit, CORDIC, sequencer.
// A waypoint beat is written to the table when it is accepted. A pose beat runs two
// distance passes (each a table read, a start and the square-root run), then a
// table read, the atan2 start, the atan2 and sine CORDIC passes and the output load.
// One pose at a time: no beat is taken until the result is loaded, and the load
// waits while an earlier result is not yet taken. Reset clears index, reached flag and
// config to defaults; table contents are undefined until written.
`timescale 1ns / 1ps
module pure_pursuit_waypoint_follower_top (
    input  logic                 clk,
    input  logic                 rst_n,
    ppwf_item_if.sink            item,
    ppwf_result_if.source        result,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data
);
    localparam int AW = ppwf_pkg::WP_AW;
    localparam int CX = ppwf_pkg::CX_W;
    localparam int CZ = ppwf_pkg::CZ_W;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;  // table read, current waypoint
    localparam logic [3:0] S_D1   = 4'd2;  // start near-check distance
    localparam logic [3:0] S_W1   = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;  // table read, last waypoint
    localparam logic [3:0] S_D2   = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_RD3  = 4'd7;  // table read, followed waypoint
    localparam logic [3:0] S_AT   = 4'd8;  // start atan2
    localparam logic [3:0] S_WA   = 4'd9;
    localparam logic [3:0] S_WS   = 4'd10; // sine running
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [15:0] radius_reg;
    logic [4:0]  npts_reg;

    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic          flag_reg, flag_next;

    logic signed [15:0] px_reg, px_next, py_reg, py_next;
    logic signed [14:0] yaw_reg, yaw_next;
    logic signed [15:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [16:0]        gdist_reg, gdist_next;
    logic signed [17:0] alpha_reg, alpha_next;
    logic signed [14:0] w_reg, w_next;

    logic               ov_reg, ov_next;
    logic [3:0]         o_idx_reg, o_idx_next;
    logic signed [15:0] o_tx_reg, o_tx_next, o_ty_reg, o_ty_next;
    logic               o_flag_reg, o_flag_next;
    logic [16:0]        o_dist_reg, o_dist_next;
    logic signed [14:0] o_w_reg, o_w_next;

    // waypoint table
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic signed [15:0] wp_x, wp_y;

    // shared units
    logic               d_start, d_done;
    logic [16:0]        d_root;
    logic signed [16:0] d_dx, d_dy;
    ppwf_pkg::cordic_cmd_t c_cmd;
    logic signed [CX-1:0] c_x0, c_y0, c_y;
    logic signed [CZ-1:0] c_z0, c_z;
    logic                 c_done;

    logic item_acc;
    logic [10:0] n_eff;
    logic [AW-1:0] last_c;

    ppwf_ram #(
        .WIDTH(32),
        .DEPTH(ppwf_pkg::MAX_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.slot)),
        .wdata ({item.pos_x, item.pos_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ppwf_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (d_start),
        .dx    (d_dx),
        .dy    (d_dy),
        .done  (d_done),
        .root  (d_root)
    );

    ppwf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (c_cmd),
        .x0    (c_x0),
        .y0    (c_y0),
        .z0    (c_z0),
        .done  (c_done),
        .y     (c_y),
        .z     (c_z)
    );

    assign wp_x = ram_rdata[31:16];
    assign wp_y = ram_rdata[15:0];

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign ram_we     = item_acc && !item.cmd && (int'(item.slot) < ppwf_pkg::MAX_WAYPOINTS);

    // waypoint count clamp: 0 acts as 1, above table depth acts as depth
    always_comb
    begin
        if (npts_reg == 5'd0)
        begin
            n_eff = 11'd1;
        end
        else if (int'(npts_reg) > ppwf_pkg::MAX_WAYPOINTS)
        begin
            n_eff = 11'(ppwf_pkg::MAX_WAYPOINTS);
        end
        else
        begin
            n_eff = 11'(npts_reg);
        end
    end
    assign last_c = AW'(n_eff - 11'd1);

    always_comb
    begin
        case (state_reg)
            S_RD2:   ram_raddr = last_reg;
            default: ram_raddr = idx_reg;
        endcase
    end

    // distance operands come straight off the table read
    assign d_dx    = 17'(wp_x) - 17'(px_reg);
    assign d_dy    = 17'(wp_y) - 17'(py_reg);
    assign d_start = (state_reg == S_D1) || (state_reg == S_D2);

    // CORDIC operand setup
    always_comb
    begin
        logic signed [CX-1:0] dx256, dy256;
        logic signed [CZ-1:0] slope_full, a, a1, a2;
        logic signed [17:0]   slope, alpha_c;
        dx256 = CX'(d_dx) <<< 8;
        dy256 = CX'(d_dy) <<< 8;
        slope_full = (c_z + CZ'(8)) >>> 4;
        slope      = 18'(slope_full);
        alpha_c    = slope - 18'(yaw_reg);
        a  = CZ'(alpha_c) <<< 4;
        a1 = a;
        if (a > ppwf_pkg::ANG_PI)
        begin
            a1 = a - ppwf_pkg::ANG_TWO_PI;
        end
        if (a1 < -ppwf_pkg::ANG_PI)
        begin
            a1 = a1 + ppwf_pkg::ANG_TWO_PI;
        end
        a2 = a1;
        if (a1 > ppwf_pkg::ANG_HALF_PI)
        begin
            a2 = ppwf_pkg::ANG_PI - a1;
        end
        if (a2 < -ppwf_pkg::ANG_HALF_PI)
        begin
            a2 = -ppwf_pkg::ANG_PI - a2;
        end
        alpha_next = alpha_reg;
        c_cmd.start     = 1'b0;
        c_cmd.vectoring = 1'b1;
        c_x0 = dx256;
        c_y0 = dy256;
        c_z0 = '0;
        if (state_reg == S_AT)
        begin
            c_cmd.start = 1'b1;
            if (d_dx < 0)
            begin
                if (d_dy >= 0)
                begin
                    c_x0 = dy256;
                    c_y0 = -dx256;
                    c_z0 = ppwf_pkg::ANG_HALF_PI;
                end
                else
                begin
                    c_x0 = -dy256;
                    c_y0 = dx256;
                    c_z0 = -ppwf_pkg::ANG_HALF_PI;
                end
            end
        end
        else if (state_reg == S_WA && c_done)
        begin
            c_cmd.start     = 1'b1;
            c_cmd.vectoring = 1'b0;
            c_x0 = ppwf_pkg::CORDIC_K;
            c_y0 = '0;
            c_z0 = a2;
            alpha_next = alpha_c;
        end
    end

    // steering rate from the sine result
    always_comb
    begin
        logic signed [CX-1:0] wf;
        logic signed [17:0]   mag, d;
        wf  = (c_y + CX'(1024)) >>> 11;
        mag = (alpha_reg < 0) ? -alpha_reg : alpha_reg;
        d   = mag - ppwf_pkg::PI_Q12;
        if (d >= -18'sd1 && d <= 18'sd1)
        begin
            w_next = ppwf_pkg::W_ONE;
        end
        else if (wf > CX'(ppwf_pkg::W_MAX))
        begin
            w_next = ppwf_pkg::W_MAX;
        end
        else if (wf < -CX'(ppwf_pkg::W_MAX))
        begin
            w_next = -ppwf_pkg::W_MAX;
        end
        else
        begin
            w_next = 15'(wf);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        flag_next  = flag_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        yaw_next   = yaw_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        gdist_next = gdist_reg;
        ov_next     = ov_reg && !result.ready;
        o_idx_next  = o_idx_reg;
        o_tx_next   = o_tx_reg;
        o_ty_next   = o_ty_reg;
        o_flag_next = o_flag_reg;
        o_dist_next = o_dist_reg;
        o_w_next    = o_w_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc && item.cmd)
                begin
                    px_next   = item.pos_x;
                    py_next   = item.pos_y;
                    yaw_next  = item.yaw;
                    last_next = last_c;
                    // stale index after num_points was lowered
                    idx_next  = (idx_reg > last_c) ? last_c : idx_reg;
                    state_next = S_RD1;
                end
            end
            S_RD1: state_next = S_D1;
            S_D1:  state_next = S_W1;
            S_W1:
            begin
                if (d_done)
                begin
                    if (d_root <= {1'b0, radius_reg})
                    begin
                        if (idx_reg < last_reg)
                        begin
                            idx_next  = idx_reg + AW'(1);
                            flag_next = ((idx_reg + AW'(1)) == last_reg);
                        end
                        else
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    state_next = S_RD2;
                end
            end
            S_RD2: state_next = S_D2;
            S_D2:  state_next = S_W2;
            S_W2:
            begin
                if (d_done)
                begin
                    gdist_next = d_root;
                    state_next = S_RD3;
                end
            end
            S_RD3: state_next = S_AT;
            S_AT:
            begin
                tx_next    = wp_x;
                ty_next    = wp_y;
                state_next = S_WA;
            end
            S_WA:
            begin
                if (c_done)
                begin
                    state_next = S_WS;
                end
            end
            S_WS:
            begin
                if (c_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next     = 1'b1;
                    o_idx_next  = 4'(idx_reg);
                    o_tx_next   = tx_reg;
                    o_ty_next   = ty_reg;
                    o_flag_next = flag_reg;
                    o_dist_next = gdist_reg;
                    o_w_next    = w_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            flag_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            radius_reg <= ppwf_pkg::GOAL_RADIUS_RST;
            npts_reg   <= ppwf_pkg::NUM_POINTS_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            flag_reg  <= flag_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ppwf_pkg::REG_GOAL_RADIUS: radius_reg <= cfg_data;
                    ppwf_pkg::REG_NUM_POINTS:  npts_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        yaw_reg    <= yaw_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        gdist_reg  <= gdist_next;
        alpha_reg  <= alpha_next;
        if (state_reg == S_WS && c_done)
        begin
            w_reg <= w_next;
        end
        o_idx_reg  <= o_idx_next;
        o_tx_reg   <= o_tx_next;
        o_ty_reg   <= o_ty_next;
        o_flag_reg <= o_flag_next;
        o_dist_reg <= o_dist_next;
        o_w_reg    <= o_w_next;
    end

    assign result.valid            = ov_reg;
    assign result.target_index     = o_idx_reg;
    assign result.target_x         = o_tx_reg;
    assign result.target_y         = o_ty_reg;
    assign result.goal_reached     = o_flag_reg;
    assign result.goal_distance    = o_dist_reg;
    assign result.angular_velocity = o_w_reg;
endmodule
